[hdl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the planar palette scan-out unit.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Store geometry
  localparam int FB_BYTES        = 262144;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PLANES          = 8;

  localparam int FB_AW    = $clog2(FB_BYTES);
  localparam int PAL_AW   = $clog2(PALETTE_ENTRIES);
  localparam int PLANE_W  = (PLANES > 1) ? $clog2(PLANES) : 1;
  // Wide enough for the last plane address plus one more stride step
  localparam int ADDR_W   = 21;

  // Field widths
  localparam int OP_W     = 2;
  localparam int FBA_W    = 18;
  localparam int PIDX_W   = 8;
  localparam int DATA_W   = 32;
  localparam int COORD_W  = 10;
  localparam int SW_W     = 10;
  localparam int SH_W     = 9;
  localparam int SCALE_W  = 2;
  localparam int OH_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW   = 10;

  // Reset values of the configuration registers
  localparam logic [SW_W-1:0]    SRC_WIDTH_RST  = 10'd320;
  localparam logic [SH_W-1:0]    SRC_HEIGHT_RST = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 2'd2;
  localparam logic [OH_W-1:0]    OUT_HEIGHT_RST = 10'd512;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PAL_WR = 2'd0,
    OP_FB_WR  = 2'd1,
    OP_PIXEL  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANAR     = 3'd0,
    CFG_WIDE       = 3'd1,
    CFG_SRC_WIDTH  = 3'd2,
    CFG_SRC_HEIGHT = 3'd3,
    CFG_SCALE_X    = 3'd4,
    CFG_SCALE_Y    = 3'd5,
    CFG_OUT_HEIGHT = 3'd6,
    CFG_SPARE      = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PLANE,
    BK_CHUNK,
    BK_EMIT
  } bk_state_t;

  // Classified word handed from front to back
  typedef struct packed {
    op_t                 kind;
    logic [ADDR_W-1:0]   addr;     // palette index, byte address or pixel base
    logic [DATA_W-1:0]   data;
    logic [2:0]          bit_sel;  // column within a plane byte
    logic                ok;       // pixel lies in drawn area and source range
    logic [COORD_W-1:0]  dest_row;
    logic [COORD_W-1:0]  dest_col;
  } pps_word_t;

  // Configuration the back end needs
  typedef struct packed {
    logic              planar;
    logic [ADDR_W-1:0] stride;
  } pps_cfg_t;

endpackage

[hdl/planar_palette_scanout_unit.sv]
// ----------------------------------------------------------------------------
// planar_palette_scanout_unit
// Palette scan-out with a byte framebuffer in chunky or eight-plane layout.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy rises only when
// the four-word queue and the front register are both full. Writes and
// requests are carried out in order, one at a time, by the back end, which
// owns single-port frame and palette memories: a palette or framebuffer
// write is done as its word is taken; a chunky pixel takes a frame read, a
// palette read and the result; a planar pixel one frame read per plane
// (through the one frame port), a palette read and the result; a request
// outside the drawn area only the result. Each result appears on the out_
// ports for exactly one cycle with out_strobe high; the receiver cannot hold
// it off. No result is given for a write or an undefined op.
module planar_palette_scanout_unit
  import pps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_op,
  input  logic [FBA_W-1:0]     in_fb_address,
  input  logic [PIDX_W-1:0]    in_palette_index,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic [COORD_W-1:0]   in_out_col,
  input  logic [COORD_W-1:0]   in_out_row,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  output logic                 out_strobe,
  output logic [DATA_W-1:0]    out_color,
  output logic [COORD_W-1:0]   out_dest_row,
  output logic [COORD_W-1:0]   out_dest_col,
  output logic                 out_drawn
);

  pps_cfg_t  cfg;
  pps_word_t push_word, head_word;
  logic      q_push, q_pop, q_full, q_empty;

  // Classify and address
  pps_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_fb_address    (in_fb_address),
    .in_palette_index (in_palette_index),
    .in_write_data    (in_write_data),
    .in_out_col       (in_out_col),
    .in_out_row       (in_out_row),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg_o            (cfg),
    .q_push           (q_push),
    .q_word           (push_word),
    .q_full           (q_full)
  );

  // Decouple front from back
  pps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .head_word (head_word),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Memory access and result
  pps_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .q_word       (head_word),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_strobe   (out_strobe),
    .out_color    (out_color),
    .out_dest_row (out_dest_row),
    .out_dest_col (out_dest_col),
    .out_drawn    (out_drawn)
  );

endmodule

[hdl/pps_queue.sv]
// ----------------------------------------------------------------------------
// pps_queue
// Short FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module pps_queue
  import pps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pps_word_t push_word,
  input  logic      pop,
  output pps_word_t head_word,
  output logic      full,
  output logic      empty
);

  pps_word_t         slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r,  count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == Q_CW'(Q_DEPTH));
  assign empty     = (count_r == '0);
  assign head_word = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

[hdl/pps_front.sv]
// ----------------------------------------------------------------------------
// pps_front
// Holds the configuration registers, accepts items, scales coordinates,
// checks the drawn area and forms the frame address of each pixel.
// ----------------------------------------------------------------------------
module pps_front
  import pps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_op,
  input  logic [FBA_W-1:0]     in_fb_address,
  input  logic [PIDX_W-1:0]    in_palette_index,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic [COORD_W-1:0]   in_out_col,
  input  logic [COORD_W-1:0]   in_out_row,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  output pps_cfg_t             cfg_o,
  output logic                 q_push,
  output pps_word_t            q_word,
  input  logic                 q_full
);

  logic                 planar_r, wide_r;
  logic [SW_W-1:0]      src_width_r;
  logic [SH_W-1:0]      src_height_r;
  logic [SCALE_W-1:0]   scale_x_r, scale_y_r;
  logic [OH_W-1:0]      out_height_r;
  logic [ADDR_W-1:0]    stride_r;
  logic [SW_W+SH_W-1:0] area;

  logic                 valid_r, valid_nxt;
  pps_word_t            word_r, word_nxt;
  logic                 accept;
  op_t                  op;

  logic [COORD_W-1:0]   x_src, y_src;
  logic [OH_W+3:0]      h9;
  logic [OH_W-1:0]      y_stop, y_off;
  logic [SW_W-1:0]      mul_a;
  logic [SW_W-1:0]      add_x;
  logic [2*COORD_W-1:0] prod;
  logic [ADDR_W-1:0]    pix_addr;
  logic                 in_area;

  // Configuration writes; unknown indexes do nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planar_r     <= 1'b0;
      wide_r       <= 1'b0;
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      scale_x_r    <= SCALE_RST;
      scale_y_r    <= SCALE_RST;
      out_height_r <= OUT_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PLANAR:     planar_r     <= cfg_data[0];
        CFG_WIDE:       wide_r       <= cfg_data[0];
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SW_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[SH_W-1:0];
        CFG_SCALE_X:    scale_x_r    <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_Y:    scale_y_r    <= cfg_data[SCALE_W-1:0];
        CFG_OUT_HEIGHT: out_height_r <= cfg_data[OH_W-1:0];
        default: ;
      endcase
    end
  end

  // Plane stride, one byte per eight pixels of the frame
  assign area = src_width_r * src_height_r;
  always_ff @(posedge clk) begin
    stride_r <= ADDR_W'(area >> 3);
  end

  assign cfg_o.planar = planar_r;
  assign cfg_o.stride = stride_r;

  // Scale down; a factor of 0 acts as 1 and 3 as 2
  assign x_src = scale_x_r[1] ? (in_out_col >> 1) : in_out_col;
  assign y_src = scale_y_r[1] ? (in_out_row >> 1) : in_out_row;

  // Drawn height and centring offset
  assign h9     = (OH_W+4)'({out_height_r, 3'b000}) + (OH_W+4)'(out_height_r);
  assign y_stop = wide_r ? h9[OH_W+3:4] : out_height_r;
  assign y_off  = wide_r ? ((out_height_r - y_stop) >> 1) : '0;

  // Frame address: one multiply and one add
  assign mul_a    = planar_r ? (src_width_r >> 3) : src_width_r;
  assign add_x    = planar_r ? (x_src >> 3) : x_src;
  assign prod     = y_src * mul_a;
  assign pix_addr = ADDR_W'(prod) + ADDR_W'(add_x);

  assign in_area = (in_out_row < y_stop) && (y_src < COORD_W'(src_height_r))
                && (x_src < src_width_r);

  assign op     = op_t'(in_op);
  assign busy   = valid_r && q_full;
  assign accept = start && !busy;
  assign q_push = valid_r;
  assign q_word = word_r;

  // Classify the item and hold it until the queue takes it
  always_comb begin
    valid_nxt         = valid_r;
    word_nxt          = word_r;
    if (valid_r && !q_full) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt         = (op != OP_NONE);
      word_nxt.kind     = op;
      word_nxt.data     = in_write_data;
      word_nxt.bit_sel  = x_src[2:0];
      word_nxt.dest_row = in_out_row + y_off;
      word_nxt.dest_col = in_out_col;
      word_nxt.ok       = in_area;
      case (op)
        OP_PAL_WR: word_nxt.addr = ADDR_W'(in_palette_index);
        OP_FB_WR:  word_nxt.addr = ADDR_W'(in_fb_address);
        default: begin
          word_nxt.addr = pix_addr;
          // Chunky byte beyond the frame store is not drawn
          if (!planar_r && (pix_addr[ADDR_W-1:FB_AW] != '0)) begin
            word_nxt.ok = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

[hdl/pps_back.sv]
// ----------------------------------------------------------------------------
// pps_back
// Owns the frame and palette memories, carries out writes and pixel lookups
// one word at a time, and drives the result strobe.
// ----------------------------------------------------------------------------
module pps_back
  import pps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  pps_cfg_t           cfg_i,
  input  pps_word_t          q_word,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_strobe,
  output logic [DATA_W-1:0]  out_color,
  output logic [COORD_W-1:0] out_dest_row,
  output logic [COORD_W-1:0] out_dest_col,
  output logic               out_drawn
);

  logic [7:0]          fb_mem  [FB_BYTES];
  logic [DATA_W-1:0]   pal_mem [PALETTE_ENTRIES];
  logic [7:0]          fb_rd_r;
  logic [DATA_W-1:0]   pal_rd_r;

  bk_state_t           state_r, state_nxt;
  logic                fb_we, fb_re, pal_we, pal_re;
  logic [FB_AW-1:0]    fb_addr;
  logic [PAL_AW-1:0]   pal_addr;

  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [PLANE_W-1:0]  plane_r, plane_nxt;
  logic [PLANES-1:0]   idx_r, idx_nxt;
  logic                bad_r, bad_nxt;
  logic                ok_r, ok_nxt;
  logic [2:0]          bit_sel_r, bit_sel_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt, col_r, col_nxt;

  logic                strobe_r, strobe_nxt;
  logic [DATA_W-1:0]   color_r, color_nxt;
  logic [COORD_W-1:0]  drow_r, drow_nxt, dcol_r, dcol_nxt;
  logic                drawn_r, drawn_nxt;

  // Sequencer: next state, memory strobes and working registers
  always_comb begin
    state_nxt   = state_r;
    q_pop       = 1'b0;
    fb_we       = 1'b0;
    fb_re       = 1'b0;
    pal_we      = 1'b0;
    pal_re      = 1'b0;
    fb_addr     = addr_r[FB_AW-1:0];
    pal_addr    = q_word.addr[PAL_AW-1:0];
    addr_nxt    = addr_r;
    plane_nxt   = plane_r;
    idx_nxt     = idx_r;
    bad_nxt     = bad_r;
    ok_nxt      = ok_r;
    bit_sel_nxt = bit_sel_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    strobe_nxt  = 1'b0;
    color_nxt   = color_r;
    drow_nxt    = drow_r;
    dcol_nxt    = dcol_r;
    drawn_nxt   = drawn_r;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          ok_nxt      = q_word.ok;
          bit_sel_nxt = q_word.bit_sel;
          row_nxt     = q_word.dest_row;
          col_nxt     = q_word.dest_col;
          fb_addr     = q_word.addr[FB_AW-1:0];
          case (q_word.kind)
            OP_PAL_WR: pal_we = 1'b1;
            OP_FB_WR:  fb_we  = 1'b1;
            default: begin
              if (!q_word.ok) begin
                state_nxt = BK_EMIT;
              end else if (cfg_i.planar) begin
                // Issue the first plane read
                fb_re     = 1'b1;
                bad_nxt   = (q_word.addr[ADDR_W-1:FB_AW] != '0);
                addr_nxt  = q_word.addr + cfg_i.stride;
                plane_nxt = '0;
                idx_nxt   = '0;
                state_nxt = BK_PLANE;
              end else begin
                fb_re     = 1'b1;
                state_nxt = BK_CHUNK;
              end
            end
          endcase
        end
      end

      BK_PLANE: begin
        // Gather this plane's bit, MSB first within the byte
        idx_nxt[plane_r] = fb_rd_r[~bit_sel_r];
        if (plane_r != PLANE_W'(PLANES - 1)) begin
          fb_re     = 1'b1;
          bad_nxt   = bad_r || (addr_r[ADDR_W-1:FB_AW] != '0);
          addr_nxt  = addr_r + cfg_i.stride;
          plane_nxt = plane_r + 1'b1;
        end else begin
          pal_re    = 1'b1;
          pal_addr  = PAL_AW'(idx_nxt);
          ok_nxt    = ok_r && !bad_r;
          state_nxt = BK_EMIT;
        end
      end

      BK_CHUNK: begin
        pal_re    = 1'b1;
        pal_addr  = PAL_AW'(fb_rd_r);
        state_nxt = BK_EMIT;
      end

      BK_EMIT: begin
        strobe_nxt = 1'b1;
        color_nxt  = ok_r ? pal_rd_r : '0;
        drow_nxt   = row_r;
        dcol_nxt   = col_r;
        drawn_nxt  = ok_r;
        state_nxt  = BK_IDLE;
      end

      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    plane_r   <= plane_nxt;
    idx_r     <= idx_nxt;
    bad_r     <= bad_nxt;
    ok_r      <= ok_nxt;
    bit_sel_r <= bit_sel_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    color_r   <= color_nxt;
    drow_r    <= drow_nxt;
    dcol_r    <= dcol_nxt;
    drawn_r   <= drawn_nxt;
  end

  // Frame memory: one port, registered read
  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fb_addr] <= q_word.data[7:0];
    end
    if (fb_re) begin
      fb_rd_r <= fb_mem[fb_addr];
    end
  end

  // Palette memory: one port, registered read
  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_addr] <= q_word.data;
    end
    if (pal_re) begin
      pal_rd_r <= pal_mem[pal_addr];
    end
  end

  assign out_strobe   = strobe_r;
  assign out_color    = color_r;
  assign out_dest_row = drow_r;
  assign out_dest_col = dcol_r;
  assign out_drawn    = drawn_r;

endmodule

[hdl/pps_checker.sv]
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks on the scan-out unit, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker
  import pps_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 busy,
  input logic                 out_strobe,
  input logic [DATA_W-1:0]    out_color,
  input logic                 out_drawn
);

  // Leave reset ready for work
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy high straight after reset");

  // No result may come out of reset
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe straight after reset");

  // Back end returns to idle between results
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results on consecutive cycles");

  // An undrawn pixel carries no colour
  a_undrawn_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_drawn) |-> (out_color == '0))
    else $error("colour on an undrawn pixel");

endmodule

bind planar_palette_scanout_unit pps_checker u_pps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_color  (out_color),
  .out_drawn  (out_drawn)
);
